[hw/rtl/sha1md_pkg.sv]
`default_nettype none
package sha1md_pkg;

	typedef struct packed {
		logic [31:0] data;
		logic        last;
	} word_t;

	localparam logic [31:0] H0_INIT = 32'h67452301;
	localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
	localparam logic [31:0] H2_INIT = 32'h98BADCFE;
	localparam logic [31:0] H3_INIT = 32'h10325476;
	localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE    = 8'h80;
	localparam logic [3:0] LEN_WORD_IX = 4'd14;
	localparam logic [6:0] LAST_ROUND  = 7'd79;

	function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (rnd < 7'd20) begin
			f = (b & c) | (~b & d);
		end else if (rnd < 7'd40) begin
			f = b ^ c ^ d;
		end else if (rnd < 7'd60) begin
			f = (b & c) | (b & d) | (c & d);
		end else begin
			f = b ^ c ^ d;
		end
		return f;
	endfunction

	function automatic logic [31:0] round_k(input logic [6:0] rnd);
		logic [31:0] k;
		if (rnd < 7'd20) begin
			k = K0;
		end else if (rnd < 7'd40) begin
			k = K1;
		end else if (rnd < 7'd60) begin
			k = K2;
		end else begin
			k = K3;
		end
		return k;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/sha1md_front.sv]
`default_nettype none
module sha1md_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire logic [7:0]          message_byte,
	input  wire logic                byte_present,
	input  wire logic                end_of_message,
	output logic                     wr_valid,
	output sha1md_pkg::word_t        wr_word,
	input  wire logic                q_full
);

	localparam logic [2:0] FS_ACC       = 3'd0;
	localparam logic [2:0] FS_PAD_FIRST = 3'd1;
	localparam logic [2:0] FS_PAD_ZERO  = 3'd2;
	localparam logic [2:0] FS_LEN_HI    = 3'd3;
	localparam logic [2:0] FS_LEN_LO    = 3'd4;

	logic [2:0]  st_q;
	logic [63:0] count_q;
	logic [31:0] word_q;
	logic [3:0]  widx_q;
	logic        accept;
	logic [31:0] pad_word;
	logic [3:0]  first_next;

	assign full       = (st_q != FS_ACC) || q_full;
	assign accept     = push && !full;
	assign first_next = count_q[5:2] + 4'd1;

	always_comb begin
		case (count_q[1:0])
			2'd0: pad_word = {sha1md_pkg::PAD_BYTE, 24'h0};
			2'd1: pad_word = {word_q[7:0], sha1md_pkg::PAD_BYTE, 16'h0};
			2'd2: pad_word = {word_q[15:0], sha1md_pkg::PAD_BYTE, 8'h0};
			default: pad_word = {word_q[23:0], sha1md_pkg::PAD_BYTE};
		endcase
	end

	always_comb begin
		wr_valid     = 1'b0;
		wr_word.data = 32'h0;
		wr_word.last = 1'b0;
		case (st_q)
			FS_ACC: begin
				wr_valid     = accept && byte_present && (count_q[1:0] == 2'd3);
				wr_word.data = {word_q[23:0], message_byte};
			end
			FS_PAD_FIRST: begin
				wr_valid     = !q_full;
				wr_word.data = pad_word;
			end
			FS_PAD_ZERO: begin
				wr_valid = !q_full;
			end
			FS_LEN_HI: begin
				wr_valid     = !q_full;
				wr_word.data = count_q[60:29];
			end
			FS_LEN_LO: begin
				wr_valid     = !q_full;
				wr_word.data = {count_q[28:0], 3'b000};
				wr_word.last = 1'b1;
			end
			default: begin
				wr_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= FS_ACC;
			count_q <= 64'h0;
			widx_q  <= 4'h0;
		end else begin
			case (st_q)
				FS_ACC: begin
					if (accept) begin
						if (byte_present) begin
							count_q <= count_q + 64'd1;
						end
						if (end_of_message) begin
							st_q <= FS_PAD_FIRST;
						end
					end
				end
				FS_PAD_FIRST: begin
					if (!q_full) begin
						widx_q <= first_next;
						st_q   <= (first_next == sha1md_pkg::LEN_WORD_IX) ? FS_LEN_HI
							: FS_PAD_ZERO;
					end
				end
				FS_PAD_ZERO: begin
					if (!q_full) begin
						widx_q <= widx_q + 4'd1;
						if (widx_q + 4'd1 == sha1md_pkg::LEN_WORD_IX) begin
							st_q <= FS_LEN_HI;
						end
					end
				end
				FS_LEN_HI: begin
					if (!q_full) begin
						st_q <= FS_LEN_LO;
					end
				end
				FS_LEN_LO: begin
					if (!q_full) begin
						count_q <= 64'h0;
						st_q    <= FS_ACC;
					end
				end
				default: begin
					st_q <= FS_ACC;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && byte_present) begin
			word_q <= {word_q[23:0], message_byte};
		end
	end

endmodule
`default_nettype wire

[hw/rtl/sha1md_fifo.sv]
`default_nettype none
module sha1md_fifo #(
	parameter int DEPTH = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                wr_valid,
	input  wire sha1md_pkg::word_t   wr_word,
	output logic                     q_full,
	input  wire logic                rd_pop,
	output sha1md_pkg::word_t        rd_word,
	output logic                     q_empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	sha1md_pkg::word_t mem [DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [CW-1:0]     cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign q_full  = (cnt_q == CW'(DEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr   = wr_valid && !q_full;
	assign do_rd   = rd_pop && !q_empty;
	assign rd_word = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue count beyond depth");

endmodule
`default_nettype wire

[hw/rtl/sha1md_back.sv]
`default_nettype none
module sha1md_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sha1md_pkg::word_t   rd_word,
	input  wire logic                q_empty,
	output logic                     rd_pop,
	output logic                     empty,
	input  wire logic                pop,
	output logic [63:0]              digest_words_0_1,
	output logic [63:0]              digest_words_2_3,
	output logic [31:0]              digest_word_4
);

	localparam logic [1:0] BS_LOAD  = 2'd0;
	localparam logic [1:0] BS_ROUND = 2'd1;
	localparam logic [1:0] BS_ADD   = 2'd2;
	localparam logic [1:0] BS_OUT   = 2'd3;

	logic [1:0]  st_q;
	logic [3:0]  ld_q;
	logic [6:0]  rnd_q;
	logic        fin_q;
	logic        out_valid_q;
	logic [31:0] h_q [5];
	logic [31:0] w_q [16];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] t;
	logic [31:0] w_mix;
	logic [31:0] w_new;
	logic        out_load;
	logic        out_take;

	assign rd_pop   = (st_q == BS_LOAD) && !q_empty;
	assign out_take = pop && out_valid_q;
	assign out_load = (st_q == BS_OUT) && (!out_valid_q || pop);
	assign empty    = !out_valid_q;

	assign w_mix = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	assign w_new = {w_mix[30:0], w_mix[31]};
	assign t = {a_q[26:0], a_q[31:27]} + sha1md_pkg::round_f(rnd_q, b_q, c_q, d_q)
		+ e_q + sha1md_pkg::round_k(rnd_q) + w_q[0];

	always_ff @(posedge clk) begin
		if (rd_pop) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= rd_word.data;
		end else if (st_q == BS_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
		end
		if (rd_pop && ld_q == 4'd15) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (st_q == BS_ROUND) begin
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
		if (out_load) begin
			digest_words_0_1 <= {h_q[0], h_q[1]};
			digest_words_2_3 <= {h_q[2], h_q[3]};
			digest_word_4    <= h_q[4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= BS_LOAD;
			ld_q        <= 4'h0;
			rnd_q       <= 7'h0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
			h_q[0]      <= sha1md_pkg::H0_INIT;
			h_q[1]      <= sha1md_pkg::H1_INIT;
			h_q[2]      <= sha1md_pkg::H2_INIT;
			h_q[3]      <= sha1md_pkg::H3_INIT;
			h_q[4]      <= sha1md_pkg::H4_INIT;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				BS_LOAD: begin
					if (rd_pop) begin
						ld_q  <= ld_q + 4'd1;
						fin_q <= rd_word.last;
						if (ld_q == 4'd15) begin
							rnd_q <= 7'h0;
							st_q  <= BS_ROUND;
						end
					end
				end
				BS_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == sha1md_pkg::LAST_ROUND) begin
						st_q <= BS_ADD;
					end
				end
				BS_ADD: begin
					h_q[0] <= h_q[0] + a_q;
					h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
					st_q   <= fin_q ? BS_OUT : BS_LOAD;
				end
				BS_OUT: begin
					if (out_load) begin
						h_q[0] <= sha1md_pkg::H0_INIT;
						h_q[1] <= sha1md_pkg::H1_INIT;
						h_q[2] <= sha1md_pkg::H2_INIT;
						h_q[3] <= sha1md_pkg::H3_INIT;
						h_q[4] <= sha1md_pkg::H4_INIT;
						st_q   <= BS_LOAD;
					end
				end
				default: begin
					st_q <= BS_LOAD;
				end
			endcase
		end
	end

	a_rounds_end: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BS_ROUND && rnd_q == sha1md_pkg::LAST_ROUND) |=> (st_q == BS_ADD))
		else $error("round counter did not close the block");

	a_block_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BS_ADD) |=> (ld_q == 4'h0))
		else $error("word load not aligned to block");

	a_digest_iv: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid_q && h_q[0] == sha1md_pkg::H0_INIT
			&& h_q[4] == sha1md_pkg::H4_INIT))
		else $error("chaining state not restored after digest");

endmodule
`default_nettype wire

[hw/rtl/sha1_message_digest_core.sv]
`default_nettype none
// Channel   Ports                                          Handshake
// input     message_byte, byte_present, end_of_message     push / full
// digest    digest_words_0_1, digest_words_2_3,             pop / empty
//           digest_word_4
//
// Bytes are taken one per cycle while the word queue has room; the queue drains
// into the round unit, which loads 16 words, runs 80 rounds and then adds into the
// chaining words for each 64-byte block, taking no new word until that add is done.
// End of message holds full for 3 to 18 padding words, and up to two blocks.
// arst_n clears the chaining words to the initial vector and the byte count to zero.
// A waiting digest stalls the round unit at the next message end, and then the input.
module sha1_message_digest_core #(
	parameter int FIFO_DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  message_byte,
	input  wire logic        byte_present,
	input  wire logic        end_of_message,
	output logic             empty,
	input  wire logic        pop,
	output logic [63:0]      digest_words_0_1,
	output logic [63:0]      digest_words_2_3,
	output logic [31:0]      digest_word_4
);

	logic              wr_valid;
	sha1md_pkg::word_t wr_word;
	logic              q_full;
	logic              rd_pop;
	sha1md_pkg::word_t rd_word;
	logic              q_empty;

	sha1md_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.message_byte   (message_byte),
		.byte_present   (byte_present),
		.end_of_message (end_of_message),
		.wr_valid       (wr_valid),
		.wr_word        (wr_word),
		.q_full         (q_full)
	);

	sha1md_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (wr_valid),
		.wr_word  (wr_word),
		.q_full   (q_full),
		.rd_pop   (rd_pop),
		.rd_word  (rd_word),
		.q_empty  (q_empty)
	);

	sha1md_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.rd_word          (rd_word),
		.q_empty          (q_empty),
		.rd_pop           (rd_pop),
		.empty            (empty),
		.pop              (pop),
		.digest_words_0_1 (digest_words_0_1),
		.digest_words_2_3 (digest_words_2_3),
		.digest_word_4    (digest_word_4)
	);

endmodule
`default_nettype wire
